// File: sv/dsf_pkg.sv
// shared constants, types and port structs of the damped string step block
// no dependencies; used by dsf_string_mem, dsf_mac and damped_string_fdtd_step
package dsf_pkg;

  localparam int NODES  = 101;
  localparam int NODE_W = $clog2(NODES);

  localparam int DATA_W      = 32;
  localparam int COEF_W      = 32;
  localparam int PROD_W      = DATA_W + COEF_W;
  localparam int ACC_W       = PROD_W + 3;
  localparam int ROUND_SHIFT = 30;
  localparam int SHIFTED_W   = ACC_W - ROUND_SHIFT;

  // 0.9 in q2.30
  localparam logic signed [COEF_W-1:0] FRET_GAIN_Q30 = 32'sd966367642;

  typedef logic [1:0] bank_t;
  localparam bank_t BANK_A = 2'd0;
  localparam bank_t BANK_B = 2'd1;
  localparam bank_t BANK_C = 2'd2;

  // one term entering the multiply-accumulate unit
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [NODE_W-1:0] addr;
  } mac_tag_t;

  // finished node from the multiply-accumulate unit
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mac_wr_t;

  // string memory write port; clr writes all three banks
  typedef struct packed {
    logic              en;
    logic              clr;
    bank_t             bank;
    logic [NODE_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// File: sv/damped_string_fdtd_step.sv
// damped string step: each input beat runs a stencil pass over the interior nodes, then the pluck,
// fret and listen fixups; the pace is set by one shared multiplier taking one stencil term per cycle
// from one memory read port
// one beat in flight at a time; a finished sample waits in the output register
// after reset a clearing pass zeroes the string; no beat is taken then
// depends on dsf_pkg, dsf_string_mem and dsf_mac
module damped_string_fdtd_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pluck_amount_i,
  input  logic               fret_enable_i,
  input  logic [6:0]         fret_node_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] listen_sample_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int NW = dsf_pkg::NODE_W;
  localparam logic [NW-1:0] LAST_NODE  = NW'(dsf_pkg::NODES - 1);
  localparam logic [NW-1:0] LAST_INNER = NW'(dsf_pkg::NODES - 2);

  typedef enum logic [2:0] {
    REG_SIDE_CUR, REG_CENTER_CUR, REG_SIDE_PREV, REG_CENTER_PREV,
    REG_PLUCK_NODE, REG_LISTEN_NODE
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_STENCIL, ST_DRAIN, ST_PLUCK_RD, ST_PLUCK_WR,
    ST_FRET_RD, ST_FRET_DRAIN, ST_LISTEN_RD, ST_LISTEN_CAP, ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    SEL_SIDE_CUR, SEL_CENTER_CUR, SEL_SIDE_PREV, SEL_CENTER_PREV, SEL_FRET
  } coef_sel_e;

  // stencil term order within one node
  localparam logic [2:0] TERM_LAST = 3'd5;

  // configuration registers
  logic signed [31:0] side_cur_q, center_cur_q, side_prev_q, center_prev_q;
  logic [6:0]         pluck_node_q, listen_node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cur_q    <= 32'sd235094000;
      center_cur_q  <= 32'sd1677296000;
      side_prev_q   <= -32'sd6411000;
      center_prev_q <= -32'sd1060920000;
      pluck_node_q  <= 7'd20;
      listen_node_q <= 7'd33;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIDE_CUR:    side_cur_q    <= cfg_data_i;
        REG_CENTER_CUR:  center_cur_q  <= cfg_data_i;
        REG_SIDE_PREV:   side_prev_q   <= cfg_data_i;
        REG_CENTER_PREV: center_prev_q <= cfg_data_i;
        REG_PLUCK_NODE:  pluck_node_q  <= cfg_data_i[6:0];
        REG_LISTEN_NODE: listen_node_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e             state_q;
  logic [1:0]         role_q;
  logic [NW-1:0]      clr_cnt_q;
  logic [NW-1:0]      node_q;
  logic [2:0]         term_q;
  logic signed [31:0] amount_q;
  logic               fret_en_q;
  logic [6:0]         fret_node_q;
  logic [31:0]        sample_q;
  logic               out_valid_q;
  logic [31:0]        out_data_q;

  // term register aligned with the memory read data
  dsf_pkg::mac_tag_t  issue_tag_q;
  coef_sel_e          issue_sel_q;

  // datapath wires
  dsf_pkg::bank_t     prv_bank, cur_bank, nxt_bank, rd_bank;
  logic [NW-1:0]      rd_addr;
  logic [31:0]        rd_data;
  dsf_pkg::mem_wr_t   mem_wr;
  dsf_pkg::mac_wr_t   mac_wr;
  logic               mac_busy;
  logic signed [31:0] coef_b;
  logic               pluck_ok, fret_ok, listen_ok;
  logic signed [32:0] pluck_sum;
  logic [31:0]        pluck_sat;
  logic [1:0]         role_next;

  function automatic dsf_pkg::bank_t bank_of(input logic [1:0] role, input logic [1:0] off);
    logic [2:0] s;
    s = {1'b0, role} + {1'b0, off};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

  always_comb begin
    prv_bank  = role_q;
    cur_bank  = bank_of(role_q, 2'd1);
    nxt_bank  = bank_of(role_q, 2'd2);
    role_next = cur_bank;

    // end nodes never take a pluck; out-of-range fret and listen nodes are ignored
    pluck_ok  = (32'(pluck_node_q) >= 32'd1) && (32'(pluck_node_q) + 32'd1 < dsf_pkg::NODES);
    fret_ok   = fret_en_q && (32'(fret_node_q) < dsf_pkg::NODES);
    listen_ok = 32'(listen_node_q) < dsf_pkg::NODES;

    pluck_sum = {rd_data[31], rd_data} + {amount_q[31], amount_q};
    if (pluck_sum[32] != pluck_sum[31]) begin
      pluck_sat = pluck_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      pluck_sat = pluck_sum[31:0];
    end
  end

  // read port: stencil operands, then the single-node fixups
  always_comb begin
    rd_bank = nxt_bank;
    rd_addr = '0;
    case (state_q)
      ST_STENCIL: begin
        rd_bank = (term_q < 3'd3) ? cur_bank : prv_bank;
        case (term_q)
          3'd0, 3'd3: rd_addr = node_q + NW'(1);
          3'd2, 3'd5: rd_addr = node_q - NW'(1);
          default:    rd_addr = node_q;
        endcase
      end
      ST_PLUCK_RD:  rd_addr = NW'(pluck_node_q);
      ST_FRET_RD:   rd_addr = NW'(fret_node_q);
      ST_LISTEN_RD: rd_addr = NW'(listen_node_q);
      default: ;
    endcase
  end

  // write port: clearing pass, finished stencil or fret node, pluck update
  always_comb begin
    mem_wr = '0;
    if (state_q == ST_CLEAR) begin
      mem_wr.en   = 1'b1;
      mem_wr.clr  = 1'b1;
      mem_wr.addr = clr_cnt_q;
    end else if (mac_wr.en) begin
      mem_wr.en   = 1'b1;
      mem_wr.bank = nxt_bank;
      mem_wr.addr = mac_wr.addr;
      mem_wr.data = mac_wr.data;
    end else if (state_q == ST_PLUCK_WR && pluck_ok) begin
      mem_wr.en   = 1'b1;
      mem_wr.bank = nxt_bank;
      mem_wr.addr = NW'(pluck_node_q);
      mem_wr.data = pluck_sat;
    end
  end

  always_comb begin
    case (issue_sel_q)
      SEL_SIDE_CUR:    coef_b = side_cur_q;
      SEL_CENTER_CUR:  coef_b = center_cur_q;
      SEL_SIDE_PREV:   coef_b = side_prev_q;
      SEL_CENTER_PREV: coef_b = center_prev_q;
      default:         coef_b = dsf_pkg::FRET_GAIN_Q30;
    endcase
  end

  dsf_string_mem u_mem (
    .clk_i     (clk_i),
    .rd_bank_i (rd_bank),
    .rd_addr_i (rd_addr),
    .wr_i      (mem_wr),
    .rd_data_o (rd_data)
  );

  dsf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (issue_tag_q),
    .a_i    (rd_data),
    .b_i    (coef_b),
    .wr_o   (mac_wr),
    .busy_o (mac_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      role_q      <= '0;
      clr_cnt_q   <= '0;
      node_q      <= '0;
      term_q      <= '0;
      issue_tag_q <= '0;
      issue_sel_q <= SEL_SIDE_CUR;
      out_valid_q <= 1'b0;
    end else begin
      // terms are issued only by the stencil and fret states
      if (state_q != ST_STENCIL && state_q != ST_FRET_RD) begin
        issue_tag_q.valid <= 1'b0;
      end
      // output beat taken; a finishing tick refills the register itself
      if (out_valid_q && out_ready_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + NW'(1);
          if (clr_cnt_q == LAST_NODE) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            node_q  <= NW'(1);
            term_q  <= '0;
            state_q <= ST_STENCIL;
          end
        end
        ST_STENCIL: begin
          // one stencil term per cycle, six per interior node
          issue_tag_q.valid <= 1'b1;
          issue_tag_q.first <= (term_q == 3'd0);
          issue_tag_q.last  <= (term_q == TERM_LAST);
          issue_tag_q.addr  <= node_q;
          case (term_q)
            3'd0, 3'd2: issue_sel_q <= SEL_SIDE_CUR;
            3'd1:       issue_sel_q <= SEL_CENTER_CUR;
            3'd3, 3'd5: issue_sel_q <= SEL_SIDE_PREV;
            default:    issue_sel_q <= SEL_CENTER_PREV;
          endcase
          if (term_q == TERM_LAST) begin
            term_q <= '0;
            if (node_q == LAST_INNER) begin
              state_q <= ST_DRAIN;
            end else begin
              node_q <= node_q + NW'(1);
            end
          end else begin
            term_q <= term_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (!issue_tag_q.valid && !mac_busy) begin
            state_q <= ST_PLUCK_RD;
          end
        end
        ST_PLUCK_RD: state_q <= ST_PLUCK_WR;
        ST_PLUCK_WR: state_q <= ST_FRET_RD;
        ST_FRET_RD: begin
          // fret damping reuses the multiplier as a one-term sum
          issue_tag_q.valid <= fret_ok;
          if (fret_ok) begin
            issue_tag_q.first <= 1'b1;
            issue_tag_q.last  <= 1'b1;
            issue_tag_q.addr  <= NW'(fret_node_q);
            issue_sel_q       <= SEL_FRET;
          end
          state_q <= ST_FRET_DRAIN;
        end
        ST_FRET_DRAIN: begin
          if (!issue_tag_q.valid && !mac_busy) begin
            state_q <= ST_LISTEN_RD;
          end
        end
        ST_LISTEN_RD: state_q <= ST_LISTEN_CAP;
        ST_LISTEN_CAP: begin
          sample_q <= listen_ok ? rd_data : '0;
          state_q  <= ST_FINISH;
        end
        ST_FINISH: begin
          // wait for a free output register, then rotate roles
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= sample_q;
            role_q      <= role_next;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // input beat fields held for the whole tick
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      amount_q    <= pluck_amount_i;
      fret_en_q   <= fret_enable_i;
      fret_node_q <= fret_node_i;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign listen_sample_o = out_data_q;

endmodule

// File: sv/dsf_string_mem.sv
// three displacement banks of the string, one write and one registered read per cycle
// depends on dsf_pkg
module dsf_string_mem (
  input  logic                         clk_i,
  input  dsf_pkg::bank_t               rd_bank_i,
  input  logic [dsf_pkg::NODE_W-1:0]   rd_addr_i,
  input  dsf_pkg::mem_wr_t             wr_i,
  output logic [dsf_pkg::DATA_W-1:0]   rd_data_o
);

  logic [dsf_pkg::DATA_W-1:0] mem_a [dsf_pkg::NODES];
  logic [dsf_pkg::DATA_W-1:0] mem_b [dsf_pkg::NODES];
  logic [dsf_pkg::DATA_W-1:0] mem_c [dsf_pkg::NODES];
  logic [dsf_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.clr || wr_i.bank == dsf_pkg::BANK_A)) begin
      mem_a[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.en && (wr_i.clr || wr_i.bank == dsf_pkg::BANK_B)) begin
      mem_b[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.en && (wr_i.clr || wr_i.bank == dsf_pkg::BANK_C)) begin
      mem_c[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    case (rd_bank_i)
      dsf_pkg::BANK_A: rd_data_q <= mem_a[rd_addr_i];
      dsf_pkg::BANK_B: rd_data_q <= mem_b[rd_addr_i];
      default:         rd_data_q <= mem_c[rd_addr_i];
    endcase
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/dsf_mac.sv
// shared multiply-accumulate unit: product, exact sum, round half up and saturate
// depends on dsf_pkg
module dsf_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dsf_pkg::mac_tag_t                  tag_i,
  input  logic signed [dsf_pkg::DATA_W-1:0]  a_i,
  input  logic signed [dsf_pkg::COEF_W-1:0]  b_i,
  output dsf_pkg::mac_wr_t                   wr_o,
  output logic                               busy_o
);

  localparam logic signed [dsf_pkg::ACC_W-1:0] HALF =
    dsf_pkg::ACC_W'(1) <<< (dsf_pkg::ROUND_SHIFT - 1);

  dsf_pkg::mac_tag_t                  tag_a_q, tag_b_q;
  logic signed [dsf_pkg::PROD_W-1:0]  prod_q;
  logic signed [dsf_pkg::ACC_W-1:0]   acc_q, acc_base, prod_ext, acc_d;
  logic signed [dsf_pkg::ACC_W-1:0]   rnd;
  logic [dsf_pkg::SHIFTED_W-1:0]      shifted;
  logic [dsf_pkg::SHIFTED_W-dsf_pkg::DATA_W:0] top_bits;
  logic [dsf_pkg::DATA_W-1:0]         sat_val;
  dsf_pkg::mac_wr_t                   wr_q;

  always_comb begin
    acc_base = tag_a_q.first ? '0 : acc_q;
    prod_ext = dsf_pkg::ACC_W'(prod_q);
    acc_d    = acc_base + prod_ext;
    rnd      = acc_q + HALF;
    shifted  = rnd[dsf_pkg::ACC_W-1:dsf_pkg::ROUND_SHIFT];
    top_bits = shifted[dsf_pkg::SHIFTED_W-1:dsf_pkg::DATA_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      sat_val = shifted[dsf_pkg::DATA_W-1:0];
    end else if (top_bits[dsf_pkg::SHIFTED_W-dsf_pkg::DATA_W]) begin
      sat_val = {1'b1, {(dsf_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(dsf_pkg::DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      wr_q    <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      wr_q.en <= tag_b_q.valid && tag_b_q.last;
      if (tag_b_q.valid && tag_b_q.last) begin
        wr_q.addr <= tag_b_q.addr;
        wr_q.data <= sat_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      prod_q <= a_i * b_i;
    end
    if (tag_a_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign wr_o   = wr_q;
  assign busy_o = tag_a_q.valid || tag_b_q.valid || wr_q.en;

endmodule
